// ===== src/image_kernel_convolution_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Image kernel convolution assertion macros
// Shorthand for the concurrent checks of the convolution unit.
// ----------------------------------------------------------------------------
`ifndef IMAGE_KERNEL_CONVOLUTION_UNIT_ASSERT_SVH
`define IMAGE_KERNEL_CONVOLUTION_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IKC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ikc check failed");

// next-cycle implication, disabled during reset
`define IKC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ikc check failed");

`endif

// ===== src/ikc_pkg.sv =====
// ----------------------------------------------------------------------------
// Image kernel convolution package
// Shared constants, register codes, line store command and arithmetic helpers.
// ----------------------------------------------------------------------------
package ikc_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;
   localparam int DEF_MAX_RADIUS = 3;

   localparam int PIX_W  = 8;
   localparam int POS_W  = 11;
   localparam int BANK_W = 3;
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 20;

   // register indexes
   localparam logic [1:0] REG_KIND   = 2'd0;
   localparam logic [1:0] REG_RADIUS = 2'd1;
   localparam logic [1:0] REG_WIDTH  = 2'd2;
   localparam logic [1:0] REG_HEIGHT = 2'd3;

   // kernel kinds
   localparam logic [1:0] KIND_BOX     = 2'd0;
   localparam logic [1:0] KIND_SHARPEN = 2'd1;
   localparam logic [1:0] KIND_LAPLACE = 2'd2;
   localparam logic [1:0] KIND_SOBEL_X = 2'd3;

   localparam logic [1:0]  RST_KIND   = KIND_BOX;
   localparam logic [1:0]  RST_RADIUS = 2'd1;
   localparam logic [11:0] RST_WIDTH  = 12'd640;
   localparam logic [11:0] RST_HEIGHT = 12'd480;

   localparam logic [2:0] ROW_MOD_LAST = 3'd5;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [BANK_W-1:0] wr_bank;
      logic [PIX_W-1:0]  wr_data;
   } ikc_ls_cmd_type;

   // row index modulo six, advanced by one
   function automatic logic [2:0] mod6_inc(input logic [2:0] m);
      mod6_inc = (m == ROW_MOD_LAST) ? 3'd0 : m + 3'd1;
   endfunction

   // ceil(2^20 / n^2), exact floor division for window sums below 2^14
   function automatic logic [RECIP_W-1:0] box_recip(input logic [1:0] rad);
      case (rad)
         2'd1:    box_recip = 17'd116509;
         2'd2:    box_recip = 17'd41944;
         default: box_recip = 17'd21400;
      endcase
   endfunction

endpackage

// ===== src/ikc_line_store.sv =====
// ----------------------------------------------------------------------------
// Image kernel convolution line store
// One row bank per buffered image line, read in parallel at one column,
// written at one bank; zeroed by a sweep after reset.
// ----------------------------------------------------------------------------
module ikc_line_store import ikc_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int NUM_BANKS = 2 * DEF_MAX_RADIUS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ikc_ls_cmd_type               cmd,
   input  logic [$clog2(MAX_WIDTH)-1:0] addr,
   output logic [PIX_W-1:0]             rd_data [NUM_BANKS],
   output logic                         busy
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic          clr_ff;
   logic          clr_in;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(MAX_WIDTH - 1)) begin
            clr_in      = 1'b0;
            clr_addr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign busy = clr_ff;

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [PIX_W-1:0] mem [MAX_WIDTH];

      always_ff @(posedge clock) begin
         if (clr_ff) begin
            mem[clr_addr_ff] <= '0;
         end else if (cmd.wr_en && cmd.wr_bank == BANK_W'(b)) begin
            mem[addr] <= cmd.wr_data;
         end
         // read-first: a same-address write shows up on the next read
         if (cmd.rd_en) begin
            rd_data[b] <= mem[addr];
         end
      end
   end

endmodule

// ===== src/image_kernel_convolution_unit.sv =====
// ----------------------------------------------------------------------------
// Image kernel convolution unit
// Streaming 2-D convolution of 8-bit grey pixels with a 3x3, 5x5 or 7x7 kernel.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while req_ready is high, and
// returns one result for every inner pixel whose window the incoming pixel
// completes; border pixels give no result. Between input and result lie
// registers at the line store read, the window update, the row sums, the
// window total, the reciprocal multiply for box blur and the output register.
// After reset the line store is zeroed one column per clock over all MAX_WIDTH
// columns, with req_ready held low; registers may be written meanwhile.
// Registers (byte address 4*i): kernel kind, kernel radius, image width,
// image height; write them only while no beat is in flight.
// ----------------------------------------------------------------------------
module image_kernel_convolution_unit import ikc_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             req_frame_start,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [PIX_W-1:0] rsp_out_pixel,
   output logic [POS_W-1:0] rsp_out_row,
   output logic [POS_W-1:0] rsp_out_col,
   output logic             rsp_last,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int WS = 2 * MAX_RADIUS + 1;
   localparam int NB = 2 * MAX_RADIUS;
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = CW + 1;
   localparam int HW = RW + 1;
   localparam int SUM_W = 14;
   localparam int ROW_W = 11;
   localparam int VAL_W = 13;
   localparam int PROD_W = SUM_W + RECIP_W;

   // ---------------- configuration registers ----------------
   logic [1:0]  kind_ff;
   logic [1:0]  rad_cfg_ff;
   logic [11:0] width_ff;
   logic [11:0] height_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= RST_KIND;
         rad_cfg_ff <= RST_RADIUS;
         width_ff   <= RST_WIDTH;
         height_ff  <= RST_HEIGHT;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_KIND:   kind_ff    <= csr_pwdata[1:0];
            REG_RADIUS: rad_cfg_ff <= csr_pwdata[1:0];
            REG_WIDTH:  width_ff   <= csr_pwdata[11:0];
            REG_HEIGHT: height_ff  <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_KIND:   csr_prdata = {30'd0, kind_ff};
         REG_RADIUS: csr_prdata = {30'd0, rad_cfg_ff};
         REG_WIDTH:  csr_prdata = {20'd0, width_ff};
         REG_HEIGHT: csr_prdata = {20'd0, height_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- effective geometry ----------------
   logic [1:0]    rad_eff;
   logic [2:0]    d_eff;
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;

   always_comb begin
      if (rad_cfg_ff == 2'd0) begin
         rad_eff = 2'd1;
      end else if (32'(rad_cfg_ff) > 32'(MAX_RADIUS)) begin
         rad_eff = 2'(MAX_RADIUS);
      end else begin
         rad_eff = rad_cfg_ff;
      end
      d_eff = {rad_eff, 1'b0};

      if (width_ff == 12'd0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end

      if (height_ff == 12'd0) begin
         h_eff = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(height_ff);
      end
   end

   // ---------------- raster position ----------------
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [2:0]    rm6_ff, rm6_in;

   logic [CW-1:0] c0, c_cur;
   logic [RW-1:0] r0, r_cur;
   logic [2:0]    m0, m1, m_cur;
   logic [HW-1:0] r1, r_nxt;
   logic [WW-1:0] c_nxt;
   logic          wrap1;
   logic [BANK_W-1:0] rmod;
   logic          emit;
   logic          last_pos;
   logic [31:0]   row_diff, col_diff;

   always_comb begin
      c0 = req_frame_start ? '0 : col_ff;
      r0 = req_frame_start ? '0 : row_ff;
      m0 = req_frame_start ? '0 : rm6_ff;

      // column left over from a narrower setting wraps first
      wrap1 = ({1'b0, c0} >= w_eff);
      c_cur = wrap1 ? '0 : c0;
      r1    = wrap1 ? ({1'b0, r0} + 1'b1) : {1'b0, r0};
      m1    = wrap1 ? mod6_inc(m0) : m0;
      if (r1 >= h_eff) begin
         r_cur = '0;
         m_cur = '0;
      end else begin
         r_cur = r1[RW-1:0];
         m_cur = m1;
      end

      c_nxt = {1'b0, c_cur} + 1'b1;
      r_nxt = {1'b0, r_cur} + 1'b1;
      if (c_nxt >= w_eff) begin
         col_in = '0;
         if (r_nxt >= h_eff) begin
            row_in = '0;
            rm6_in = '0;
         end else begin
            row_in = r_nxt[RW-1:0];
            rm6_in = mod6_inc(m_cur);
         end
      end else begin
         col_in = c_nxt[CW-1:0];
         row_in = r_cur;
         rm6_in = m_cur;
      end

      case (rad_eff)
         2'd1:    rmod = {2'b00, r_cur[0]};
         2'd2:    rmod = {1'b0, r_cur[1:0]};
         default: rmod = m_cur;
      endcase

      emit     = (32'(r_cur) >= 32'(d_eff)) && (32'(c_cur) >= 32'(d_eff));
      last_pos = (32'(r_cur) == 32'(h_eff) - 32'd1) && (32'(c_cur) == 32'(w_eff) - 32'd1);
      row_diff = 32'(r_cur) - 32'(rad_eff);
      col_diff = 32'(c_cur) - 32'(rad_eff);
   end

   // ---------------- handshake ----------------
   logic rsp_valid_ff;
   logic advance;
   logic accept;
   logic ls_busy;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance && !ls_busy;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         rm6_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         rm6_ff <= rm6_in;
      end
   end

   // ---------------- line store ----------------
   ikc_ls_cmd_type   ls_cmd;
   logic [PIX_W-1:0] ls_rd [NB];

   always_comb begin
      ls_cmd.rd_en   = accept;
      ls_cmd.wr_en   = accept;
      ls_cmd.wr_bank = rmod;
      ls_cmd.wr_data = req_pixel;
   end

   ikc_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .NUM_BANKS (NB)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ls_cmd),
      .addr    (c_cur),
      .rd_data (ls_rd),
      .busy    (ls_busy)
   );

   // ---------------- stage 1: accepted beat ----------------
   logic             p1_valid_ff;
   logic             p1_emit_ff;
   logic [PIX_W-1:0] p1_pix_ff;
   logic [1:0]       p1_rad_ff;
   logic [1:0]       p1_kind_ff;
   logic [BANK_W-1:0] p1_rmod_ff;
   logic [POS_W-1:0] p1_row_ff, p1_col_ff;
   logic             p1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && accept) begin
         p1_emit_ff <= emit;
         p1_pix_ff  <= req_pixel;
         p1_rad_ff  <= rad_eff;
         p1_kind_ff <= kind_ff;
         p1_rmod_ff <= rmod;
         p1_row_ff  <= row_diff[POS_W-1:0];
         p1_col_ff  <= col_diff[POS_W-1:0];
         p1_last_ff <= last_pos;
      end
   end

   // ---------------- window update ----------------
   logic [PIX_W-1:0] win_ff [WS][WS];
   logic [PIX_W-1:0] win_in [WS][WS];
   logic [PIX_W-1:0] new_col [WS];
   logic [2:0]       p1_d;
   logic [2:0]       p1_n;
   logic [BANK_W:0]  bank_idx [NB];

   always_comb begin
      p1_d = {p1_rad_ff, 1'b0};
      p1_n = {p1_rad_ff, 1'b1};

      // map buffered line i to its bank: (row + i) mod d
      for (int i = 0; i < NB; i++) begin
         bank_idx[i] = {1'b0, p1_rmod_ff} + (BANK_W + 1)'(i);
         if (bank_idx[i] >= {1'b0, p1_d}) begin
            bank_idx[i] = bank_idx[i] - {1'b0, p1_d};
         end
      end

      for (int i = 0; i < WS; i++) begin
         new_col[i] = p1_pix_ff;
      end
      for (int i = 0; i < NB; i++) begin
         for (int b = 0; b < NB; b++) begin
            if (i < p1_d && bank_idx[i] == (BANK_W + 1)'(b)) begin
               new_col[i] = ls_rd[b];
            end
         end
      end

      win_in = win_ff;
      if (p1_valid_ff) begin
         for (int i = 0; i < WS; i++) begin
            for (int j = 0; j < WS - 1; j++) begin
               if (i < p1_n && j < p1_d) begin
                  win_in[i][j] = win_ff[i][j + 1];
               end
            end
            for (int j = 0; j < WS; j++) begin
               if (i < p1_n && j == p1_d) begin
                  win_in[i][j] = new_col[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WS; i++) begin
            for (int j = 0; j < WS; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (advance) begin
         win_ff <= win_in;
      end
   end

   // ---------------- stage 2: window holds this beat ----------------
   logic             p2_valid_ff;
   logic [1:0]       p2_rad_ff, p2_kind_ff;
   logic [POS_W-1:0] p2_row_ff, p2_col_ff;
   logic             p2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p2_valid_ff <= p1_valid_ff && p1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_rad_ff  <= p1_rad_ff;
         p2_kind_ff <= p1_kind_ff;
         p2_row_ff  <= p1_row_ff;
         p2_col_ff  <= p1_col_ff;
         p2_last_ff <= p1_last_ff;
      end
   end

   // row sums and the small-kernel value
   logic [ROW_W-1:0]        row_sum [WS];
   logic [2:0]              p2_n;
   logic [PIX_W-1:0]        nb_c, nb_n, nb_s, nb_w, nb_e, nb_nw, nb_ne, nb_sw, nb_se;
   logic signed [VAL_W-1:0] vc, vn, vs, vw, ve, vnw, vne, vsw, vse;
   logic signed [VAL_W-1:0] small_val;

   always_comb begin
      p2_n = {p2_rad_ff, 1'b1};
      for (int i = 0; i < WS; i++) begin
         row_sum[i] = '0;
         for (int j = 0; j < WS; j++) begin
            if (j < p2_n) begin
               row_sum[i] = row_sum[i] + ROW_W'(win_ff[i][j]);
            end
         end
      end

      nb_c  = win_ff[1][1];
      nb_n  = win_ff[0][1];
      nb_s  = win_ff[2][1];
      nb_w  = win_ff[1][0];
      nb_e  = win_ff[1][2];
      nb_nw = win_ff[0][0];
      nb_ne = win_ff[0][2];
      nb_sw = win_ff[2][0];
      nb_se = win_ff[2][2];
      for (int k = 2; k <= MAX_RADIUS; k++) begin
         if (p2_rad_ff == 2'(k)) begin
            nb_c  = win_ff[k][k];
            nb_n  = win_ff[k - 1][k];
            nb_s  = win_ff[k + 1][k];
            nb_w  = win_ff[k][k - 1];
            nb_e  = win_ff[k][k + 1];
            nb_nw = win_ff[k - 1][k - 1];
            nb_ne = win_ff[k - 1][k + 1];
            nb_sw = win_ff[k + 1][k - 1];
            nb_se = win_ff[k + 1][k + 1];
         end
      end

      vc  = $signed({5'd0, nb_c});
      vn  = $signed({5'd0, nb_n});
      vs  = $signed({5'd0, nb_s});
      vw  = $signed({5'd0, nb_w});
      ve  = $signed({5'd0, nb_e});
      vnw = $signed({5'd0, nb_nw});
      vne = $signed({5'd0, nb_ne});
      vsw = $signed({5'd0, nb_sw});
      vse = $signed({5'd0, nb_se});

      case (p2_kind_ff)
         KIND_SHARPEN: small_val = (vc <<< 2) + vc - vn - vs - vw - ve;
         KIND_LAPLACE: small_val = (vc <<< 3) - vn - vs - vw - ve - vnw - vne - vsw - vse;
         KIND_SOBEL_X: small_val = (vnw + (vw <<< 1) + vsw) - (vne + (ve <<< 1) + vse);
         default:      small_val = '0;
      endcase
   end

   // ---------------- stage 3 ----------------
   logic                    p3_valid_ff;
   logic [1:0]              p3_rad_ff, p3_kind_ff;
   logic [POS_W-1:0]        p3_row_ff, p3_col_ff;
   logic                    p3_last_ff;
   logic [ROW_W-1:0]        p3_row_sum_ff [WS];
   logic signed [VAL_W-1:0] p3_small_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (advance) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p3_rad_ff     <= p2_rad_ff;
         p3_kind_ff    <= p2_kind_ff;
         p3_row_ff     <= p2_row_ff;
         p3_col_ff     <= p2_col_ff;
         p3_last_ff    <= p2_last_ff;
         p3_row_sum_ff <= row_sum;
         p3_small_ff   <= small_val;
      end
   end

   logic [SUM_W-1:0] box_total;
   logic [2:0]       p3_n;

   always_comb begin
      p3_n = {p3_rad_ff, 1'b1};
      box_total = '0;
      for (int i = 0; i < WS; i++) begin
         if (i < p3_n) begin
            box_total = box_total + SUM_W'(p3_row_sum_ff[i]);
         end
      end
   end

   // ---------------- stage 4 ----------------
   logic                    p4_valid_ff;
   logic [1:0]              p4_rad_ff, p4_kind_ff;
   logic [POS_W-1:0]        p4_row_ff, p4_col_ff;
   logic                    p4_last_ff;
   logic [SUM_W-1:0]        p4_total_ff;
   logic signed [VAL_W-1:0] p4_small_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (advance) begin
         p4_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p4_rad_ff   <= p3_rad_ff;
         p4_kind_ff  <= p3_kind_ff;
         p4_row_ff   <= p3_row_ff;
         p4_col_ff   <= p3_col_ff;
         p4_last_ff  <= p3_last_ff;
         p4_total_ff <= box_total;
         p4_small_ff <= p3_small_ff;
      end
   end

   // ---------------- stage 5: reciprocal multiply ----------------
   logic                    p5_valid_ff;
   logic [1:0]              p5_kind_ff;
   logic [POS_W-1:0]        p5_row_ff, p5_col_ff;
   logic                    p5_last_ff;
   logic [PROD_W-1:0]       p5_prod_ff;
   logic signed [VAL_W-1:0] p5_small_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else if (advance) begin
         p5_valid_ff <= p4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p5_kind_ff  <= p4_kind_ff;
         p5_row_ff   <= p4_row_ff;
         p5_col_ff   <= p4_col_ff;
         p5_last_ff  <= p4_last_ff;
         p5_prod_ff  <= PROD_W'(p4_total_ff) * PROD_W'(box_recip(p4_rad_ff));
         p5_small_ff <= p4_small_ff;
      end
   end

   logic [PIX_W-1:0] result_pix;

   always_comb begin
      if (p5_kind_ff == KIND_BOX) begin
         result_pix = p5_prod_ff[RECIP_SHIFT + PIX_W - 1:RECIP_SHIFT];
      end else if (p5_small_ff < 0) begin
         result_pix = '0;
      end else if (p5_small_ff > $signed(VAL_W'(255))) begin
         result_pix = '1;
      end else begin
         result_pix = p5_small_ff[PIX_W-1:0];
      end
   end

   // ---------------- output register ----------------
   logic [PIX_W-1:0] rsp_pix_ff;
   logic [POS_W-1:0] rsp_row_ff, rsp_col_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= p5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pix_ff  <= result_pix;
         rsp_row_ff  <= p5_row_ff;
         rsp_col_ff  <= p5_col_ff;
         rsp_last_ff <= p5_last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_pix_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== src/ikc_checker.sv =====
// ----------------------------------------------------------------------------
// Image kernel convolution checker
// Port-level checks of the convolution unit, attached by bind.
// ----------------------------------------------------------------------------
`include "image_kernel_convolution_unit_assert.svh"

module ikc_port_checker import ikc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] rsp_out_pixel,
   input logic [POS_W-1:0] rsp_out_row,
   input logic [POS_W-1:0] rsp_out_col,
   input logic             rsp_last,
   input logic             csr_pready
);

   // a stalled result beat holds its payload
   `IKC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_pixel) && $stable(rsp_out_row)
      && $stable(rsp_out_col) && $stable(rsp_last))

   // input is taken only when the result side can move
   `IKC_ASSERT_IMPLY(a_ready_flow, clock, reset, req_ready, !rsp_valid || rsp_ready)

   // line store sweep blocks input right after reset
   `IKC_ASSERT_IMPLY(a_clear_after_reset, clock, reset, $past(reset), !req_ready)

   // the last inner pixel never lies on the border
   `IKC_ASSERT_IMPLY(a_last_inner, clock, reset, rsp_valid && rsp_last,
      rsp_out_row != 0 && rsp_out_col != 0)

   `IKC_ASSERT_IMPLY(a_pready, clock, reset, 1'b1, csr_pready)

endmodule

bind image_kernel_convolution_unit ikc_port_checker u_ikc_checker (.*);

// ===== verif/ikc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Convolution result checker
// Watches the register port and both pixel channels, predicts every result
// of the convolution unit and compares it field by field with what comes out.
// ----------------------------------------------------------------------------
module ikc_checker import ikc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             req_frame_start,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [PIX_W-1:0] rsp_out_pixel,
   input  logic [POS_W-1:0] rsp_out_row,
   input  logic [POS_W-1:0] rsp_out_col,
   input  logic             rsp_last,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   input  logic             csr_pready,
   output int               fail_count,
   output int               pending
);

   localparam int SIDE  = 2 * DEF_MAX_RADIUS + 1;
   localparam int LINES = 2 * DEF_MAX_RADIUS;

   typedef struct {
      logic [PIX_W-1:0] value;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             last;
   } conv_result_type;

   conv_result_type  conv_expected_q[$];
   logic [PIX_W-1:0] line_mem[0:LINES*DEF_MAX_WIDTH-1];
   logic [PIX_W-1:0] win[0:SIDE-1][0:SIDE-1];
   int               row_pos, col_pos;
   logic [1:0]       kind_reg, radius_reg;
   logic [11:0]      width_reg, height_reg;

   function automatic int win_px(int i, int j);
      return int'(win[i][j]);
   endfunction

   function automatic int kernel_sum(int rad);
      int n, s;
      n = 2 * rad + 1;
      s = 0;
      case (kind_reg)
         KIND_BOX: begin
            for (int i = 0; i < n; i++)
               for (int j = 0; j < n; j++)
                  s += win_px(i, j);
            return s / (n * n);
         end
         KIND_SHARPEN:
            return 5 * win_px(rad, rad) - win_px(rad - 1, rad) - win_px(rad + 1, rad)
                   - win_px(rad, rad - 1) - win_px(rad, rad + 1);
         KIND_LAPLACE: begin
            for (int i = rad - 1; i <= rad + 1; i++)
               for (int j = rad - 1; j <= rad + 1; j++)
                  s -= win_px(i, j);
            return s + 9 * win_px(rad, rad);
         end
         default:
            return (win_px(rad - 1, rad - 1) + 2 * win_px(rad, rad - 1)
                    + win_px(rad + 1, rad - 1))
                 - (win_px(rad - 1, rad + 1) + 2 * win_px(rad, rad + 1)
                    + win_px(rad + 1, rad + 1));
      endcase
   endfunction

   task automatic take_pixel(input logic [PIX_W-1:0] pix, input logic fs);
      int rad, w, h, n, d, v;
      conv_result_type res;
      rad = (radius_reg == 0) ? 1 : int'(radius_reg);
      w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : int'(width_reg));
      h = (height_reg == 0) ? 1
          : (height_reg > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : int'(height_reg));
      n = 2 * rad + 1;
      d = 2 * rad;
      if (fs) begin
         row_pos = 0;
         col_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      // shift left one column, load the new column from the line rows
      for (int i = 0; i < n; i++)
         for (int j = 0; j + 1 < n; j++)
            win[i][j] = win[i][j+1];
      for (int i = 0; i < d; i++)
         win[i][d] = line_mem[((row_pos + i) % d) * DEF_MAX_WIDTH + col_pos];
      win[d][d] = pix;
      line_mem[(row_pos % d) * DEF_MAX_WIDTH + col_pos] = pix;
      if (row_pos >= d && col_pos >= d) begin
         v = kernel_sum(rad);
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         res.value = v[PIX_W-1:0];
         res.row   = POS_W'(row_pos - rad);
         res.col   = POS_W'(col_pos - rad);
         res.last  = (row_pos == h - 1 && col_pos == w - 1);
         conv_expected_q.push_back(res);
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   always @(posedge clock) begin
      conv_result_type exp_res;
      if (reset) begin
         foreach (line_mem[k]) line_mem[k] = '0;
         foreach (win[i, j]) win[i][j] = '0;
         row_pos    = 0;
         col_pos    = 0;
         kind_reg   = RST_KIND;
         radius_reg = RST_RADIUS;
         width_reg  = RST_WIDTH;
         height_reg = RST_HEIGHT;
         conv_expected_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (conv_expected_q.size() == 0) begin
               $display("%t unexpected result beat: pixel %0d row %0d col %0d last %0d",
                        $time, rsp_out_pixel, rsp_out_row, rsp_out_col, rsp_last);
               fail_count++;
            end else begin
               exp_res = conv_expected_q.pop_front();
               if (rsp_out_pixel !== exp_res.value || rsp_out_row !== exp_res.row ||
                   rsp_out_col !== exp_res.col || rsp_last !== exp_res.last) begin
                  $display("%t mismatch: expected pixel %0d row %0d col %0d last %0d, ",
                           $time, exp_res.value, exp_res.row, exp_res.col, exp_res.last,
                           "got pixel %0d row %0d col %0d last %0d",
                           rsp_out_pixel, rsp_out_row, rsp_out_col, rsp_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) take_pixel(req_pixel, req_frame_start);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_KIND:   kind_reg   = csr_pwdata[1:0];
               REG_RADIUS: radius_reg = csr_pwdata[1:0];
               REG_WIDTH:  width_reg  = csr_pwdata[11:0];
               default:    height_reg = csr_pwdata[11:0];
            endcase
         end
      end
      pending = conv_expected_q.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Convolution unit testbench
// Streams raster frames under many kernel and size settings with random
// stalls on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb import ikc_pkg::*;;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [PIX_W-1:0] req_pixel = '0;
   logic             req_frame_start = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [PIX_W-1:0] rsp_out_pixel;
   logic [POS_W-1:0] rsp_out_row, rsp_out_col;
   logic             rsp_last;
   logic             csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0]       csr_paddr = '0;
   logic [31:0]      csr_pwdata = '0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;
   int               fail_count, pending;
   int               pixels_sent = 0;
   bit               calm = 1'b0;

   always #2 clock = ~clock;

   image_kernel_convolution_unit DUT (.*);

   ikc_checker u_checker (.*);

   // result side back-pressure
   always @(negedge clock)
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input logic [1:0] kind, input logic [1:0] rad,
                            input logic [11:0] w, input logic [11:0] h);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_write(REG_KIND, 32'(kind));
      csr_write(REG_RADIUS, 32'(rad));
      csr_write(REG_WIDTH, 32'(w));
      csr_write(REG_HEIGHT, 32'(h));
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel       <= pix;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      pixels_sent++;
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel(int mode);
      case (mode)
         0:       return $urandom_range(1) ? 8'hFF : 8'h00;
         1:       return PIX_W'($urandom_range(255, 200));
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   // one raster frame, sometimes broken by a stray frame mark, a short tail or extra pixels
   task automatic send_frame(input int w, input int h, input bit noisy);
      int mode, total;
      mode  = $urandom_range(2);
      total = w * h;
      if (noisy) total = $urandom_range(w * h + w, w);
      for (int k = 0; k < total; k++)
         send_pixel(rand_pixel(mode), k == 0 || (noisy && $urandom_range(99) == 0));
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   initial begin
      int w, h;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: vertical stripes of extremes through a 7x7 image, every kind
      for (int k = 0; k < 4; k++) begin
         idle_sender();
         configure(k[1:0], 2'd1, 12'd7, 12'd7);
         for (int p = 0; p < 49; p++)
            send_pixel(((p + p / 7) % 2 == 1) ? 8'hFF : 8'h00, p == 0);
      end
      // all-max image through the largest box (largest sum) and radius zero
      idle_sender();
      configure(KIND_BOX, 2'd3, 12'd7, 12'd7);
      for (int p = 0; p < 49; p++) send_pixel(8'hFF, p == 0);
      idle_sender();
      configure(KIND_LAPLACE, 2'd0, 12'd7, 12'd8);
      send_frame(7, 8, 1'b0);
      // degenerate and saturated sizes, plus a small image that is too narrow
      idle_sender();
      configure(KIND_SOBEL_X, 2'd2, 12'd0, 12'd0);
      for (int p = 0; p < 20; p++) send_pixel(rand_pixel(2), p == 0);
      idle_sender();
      configure(KIND_SHARPEN, 2'd1, 12'hFFF, 12'hFFF);
      for (int p = 0; p < 40; p++) send_pixel(rand_pixel(2), p == 0);
      idle_sender();
      configure(KIND_BOX, 2'd3, 12'd5, 12'd9);
      send_frame(5, 9, 1'b0);

      // random settings, well-formed frames with some noise
      while (pixels_sent < 1250) begin
         idle_sender();
         calm = ($urandom_range(7) == 0);
         w = $urandom_range(16, 7);
         h = $urandom_range(11, 7);
         configure(2'($urandom_range(3)), 2'($urandom_range(3)), 12'(w), 12'(h));
         repeat ($urandom_range(2, 1))
            send_frame(w, h, $urandom_range(4) == 0);
      end
      idle_sender();
      calm = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
